[rtl/wsue_pkg.sv]
`default_nettype none

package wsue_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [7:0] ECHO_HDR = 8'h81;
	localparam logic [7:0] LEN_MASK = 8'h7F;
	localparam int unsigned MASK_BIT = 7;
	localparam logic [6:0] LEN_EXT = 7'd126;

	typedef enum logic [1:0] {
		PH_HDR0,
		PH_HDR1,
		PH_KEY,
		PH_DATA
	} phase_t;

	typedef enum logic [1:0] {
		OP_HDR,
		OP_DATA,
		OP_BAD
	} op_kind_t;

	// One queued operation: the echo header plus length, a payload byte, or an error
	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] data;
		logic       last;
	} op_t;

endpackage

`default_nettype wire

[rtl/wsue_front.sv]
`default_nettype none

module wsue_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    in_byte,
	input  wire logic          q_full,
	output logic               push,
	output wsue_pkg::op_t      push_op
);
	import wsue_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] key_q [4];
	logic       mask_q, mask_d;
	logic [6:0] left_q, left_d;
	logic [1:0] kidx_q, kidx_d;
	logic       key_we;
	logic       take;
	logic [6:0] len;
	logic       ext_len;
	logic [6:0] left_dec;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;
	assign len      = in_byte[6:0] & LEN_MASK[6:0];
	assign ext_len  = (len >= LEN_EXT);
	assign left_dec = left_q - 7'd1;

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (take) begin
			unique case (phase_q)
				PH_HDR0: phase_d = PH_HDR1;
				PH_HDR1: begin
					if (ext_len)
						phase_d = PH_HDR0;
					else if (in_byte[MASK_BIT])
						phase_d = PH_KEY;
					else
						phase_d = (len == 7'd0) ? PH_HDR0 : PH_DATA;
				end
				PH_KEY: begin
					if (kidx_q == 2'd3)
						phase_d = (left_q == 7'd0) ? PH_HDR0 : PH_DATA;
				end
				PH_DATA: begin
					if (left_dec == 7'd0)
						phase_d = PH_HDR0;
				end
			endcase
		end
	end

	// Frame context updates and queue writes
	always_comb begin
		mask_d  = mask_q;
		left_d  = left_q;
		kidx_d  = kidx_q;
		key_we  = 1'b0;
		push    = 1'b0;
		push_op = '{kind: OP_DATA, data: 8'd0, last: 1'b0};
		if (take) begin
			unique case (phase_q)
				PH_HDR0: ;
				PH_HDR1: begin
					push = 1'b1;
					if (ext_len) begin
						push_op = '{kind: OP_BAD, data: 8'd0, last: 1'b0};
					end else begin
						mask_d  = in_byte[MASK_BIT];
						left_d  = len;
						kidx_d  = 2'd0;
						push_op = '{kind: OP_HDR, data: {1'b0, len}, last: (len == 7'd0)};
					end
				end
				PH_KEY: begin
					key_we = 1'b1;
					kidx_d = kidx_q + 2'd1;
				end
				PH_DATA: begin
					kidx_d  = kidx_q + 2'd1;
					left_d  = left_dec;
					push    = 1'b1;
					push_op = '{kind: OP_DATA,
						data: mask_q ? (in_byte ^ key_q[kidx_q]) : in_byte,
						last: (left_dec == 7'd0)};
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			mask_q  <= 1'b0;
			left_q  <= 7'd0;
			kidx_q  <= 2'd0;
			key_q   <= '{default: 8'd0};
		end else begin
			phase_q <= phase_d;
			mask_q  <= mask_d;
			left_q  <= left_d;
			kidx_q  <= kidx_d;
			if (key_we)
				key_q[kidx_q] <= in_byte;
		end
	end

endmodule

`default_nettype wire

[rtl/wsue_fifo.sv]
`default_nettype none

module wsue_fifo #(
	parameter int unsigned Depth = wsue_pkg::QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire wsue_pkg::op_t push_op,
	output logic               full,
	input  wire logic          pop,
	output wsue_pkg::op_t      pop_op,
	output logic               empty
);
	import wsue_pkg::*;

	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CW = $clog2(Depth + 1);
	localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);

	op_t           slot_q [Depth];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == CW'(Depth));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_op  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == LastPtr) ? '0 : wr_q + AW'(1);
			if (do_pop)
				rd_q <= (rd_q == LastPtr) ? '0 : rd_q + AW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

`default_nettype wire

[rtl/wsue_back.sv]
`default_nettype none

module wsue_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_empty,
	input  wire wsue_pkg::op_t q_op,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [7:0]         out_byte,
	output logic               out_last,
	output logic               out_bad
);
	import wsue_pkg::*;

	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       bad_q;
	// Length byte still owed after the echo header
	logic       pend_q;
	logic [7:0] pend_byte_q;
	logic       pend_last_q;
	logic       load;

	assign load      = !valid_q || out_ready;
	assign pop       = load && !pend_q && !q_empty;
	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;
	assign out_bad   = bad_q;

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				byte_q <= pend_byte_q;
				last_q <= pend_last_q;
				bad_q  <= 1'b0;
			end else if (!q_empty) begin
				unique case (q_op.kind)
					OP_HDR: begin
						byte_q      <= ECHO_HDR;
						last_q      <= 1'b0;
						bad_q       <= 1'b0;
						pend_byte_q <= q_op.data;
						pend_last_q <= q_op.last;
					end
					OP_BAD: begin
						byte_q <= 8'd0;
						last_q <= 1'b0;
						bad_q  <= 1'b1;
					end
					default: begin
						byte_q <= q_op.data;
						last_q <= q_op.last;
						bad_q  <= 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else begin
				valid_q <= !q_empty;
				pend_q  <= !q_empty && (q_op.kind == OP_HDR);
			end
		end
	end

endmodule

`default_nettype wire

[rtl/websocket_frame_unmask_echo.sv]
`default_nettype none

// WebSocket echo unmasker for short frames. Feed the raw frame stream one byte per item on the
// s_ side; the m_ side returns, per frame, the echo header 0x81, the 7-bit payload length and
// the payload with the client mask removed (unmasked frames pass through as they are), tlast
// set on the final byte of each echo frame (on the length byte itself for an empty frame). The
// first header byte of a frame is dropped and the four mask key bytes give no output. A length
// code of 126 or 127 yields a single item with tuser = 1 and data 0, after which the next byte
// is taken as the first header byte of a new frame. Rate: one input byte per cycle and one
// output byte per cycle, sustained while m_tready stays high. The front end classifies each
// byte and removes the mask combinationally and writes the queue at the edge that accepts the
// byte; the back end loads its output register from the queue once that register is empty or
// being taken, and each output item is presented from that register. A header expands into
// two output items from that register, the echo header followed by the length byte. A queue of
// QueueDepth entries between them lets either side stall on its own; the front stalls only
// when that queue is full, which the two-item header cannot cause on its own since the first
// header byte of every frame gives no output and so leaves the back end time to catch up.
module websocket_frame_unmask_echo #(
	parameter int unsigned QueueDepth = wsue_pkg::QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,  // [7:0] frame_byte
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,  // [7:0] out_byte
	output logic            m_tlast,  // out_last
	output logic            m_tuser   // [0] bad_length
);
	import wsue_pkg::*;

	op_t  push_op, pop_op;
	logic push, q_full, pop, q_empty;

	// Front: track the frame header, capture the key, unmask payload
	wsue_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.q_full   (q_full),
		.push     (push),
		.push_op  (push_op)
	);

	// Decouple classification from output framing
	wsue_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (q_full),
		.pop     (pop),
		.pop_op  (pop_op),
		.empty   (q_empty)
	);

	// Back: expand queued operations into echo items, hold them under backpressure
	wsue_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_op      (pop_op),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_last  (m_tlast),
		.out_bad   (m_tuser)
	);

endmodule

`default_nettype wire

[tb/sv/tb_websocket_frame_unmask_echo.sv]
module tb_websocket_frame_unmask_echo;
	timeunit 1ns;
	timeprecision 1ps;

	import wsue_pkg::*;

	// One echo output item as the block should present it
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       bad;
	} echo_item_t;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 375;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 20;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;  // [7:0] frame_byte
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;          // [7:0] out_byte
	logic       m_tlast;          // out_last
	logic       m_tuser;          // [0] bad_length

	// Raw frame bytes waiting to be offered, and echo items still owed by the block
	logic [7:0] tx_bytes[$];
	echo_item_t echo_q[$];

	int errors = 0;
	int cycles = 0;
	int queued_n = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;

	// Shadow of the unmasker state
	phase_t     sh_phase = PH_HDR0;
	logic [7:0] sh_key[4] = '{default: 8'h00};
	logic       sh_masked = 1'b0;
	logic [6:0] sh_left = 7'd0;
	logic [1:0] sh_kidx = 2'd0;

	websocket_frame_unmask_echo u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycles, what);
		errors++;
	endtask

	// Advance the shadow state by one accepted frame byte and queue the echo items it causes.
	function automatic void unmask_step(input logic [7:0] b);
		logic [6:0] len;
		logic [7:0] v;
		len = b[6:0];
		case (sh_phase)
			PH_HDR1: begin
				if (len >= LEN_EXT) begin
					// Extended length: one error item, then look for a new frame
					echo_q.push_back('{data: 8'h00, last: 1'b0, bad: 1'b1});
					sh_phase = PH_HDR0;
				end else begin
					sh_masked = b[MASK_BIT];
					sh_left = len;
					sh_kidx = 2'd0;
					echo_q.push_back('{data: ECHO_HDR, last: 1'b0, bad: 1'b0});
					echo_q.push_back('{data: {1'b0, len}, last: (len == 7'd0), bad: 1'b0});
					if (sh_masked)
						sh_phase = PH_KEY;
					else
						sh_phase = (len == 7'd0) ? PH_HDR0 : PH_DATA;
				end
			end
			PH_KEY: begin
				// Key bytes give no output; an empty masked frame ends after the fourth
				sh_key[sh_kidx] = b;
				sh_kidx = sh_kidx + 2'd1;
				if (sh_kidx == 2'd0)
					sh_phase = (sh_left == 7'd0) ? PH_HDR0 : PH_DATA;
			end
			PH_DATA: begin
				v = sh_masked ? (b ^ sh_key[sh_kidx]) : b;
				sh_kidx = sh_kidx + 2'd1;
				sh_left = sh_left - 7'd1;
				echo_q.push_back('{data: v, last: (sh_left == 7'd0), bad: 1'b0});
				if (sh_left == 7'd0)
					sh_phase = PH_HDR0;
			end
			default: sh_phase = PH_HDR1;
		endcase
	endfunction

	task automatic queue_byte(input logic [7:0] b);
		tx_bytes.push_back(b);
		queued_n++;
	endtask

	// Queue one random frame: mostly well formed with random content, some with an
	// extended length code, and a little raw noise that throws the framing off.
	task automatic queue_frame();
		int sel;
		int len;
		logic masked;
		sel = $urandom_range(99);
		if (sel < 5) begin
			repeat ($urandom_range(1, 6)) queue_byte(8'($urandom));
		end else begin
			queue_byte(8'($urandom));
			if (sel < 12) begin
				queue_byte({1'($urandom), 7'(126 + $urandom_range(1))});
			end else begin
				sel = $urandom_range(99);
				if (sel < 2)
					len = 125;
				else if (sel < 10)
					len = $urandom_range(13, 60);
				else
					len = $urandom_range(0, 12);
				masked = ($urandom_range(99) < 70);
				queue_byte({masked, 7'(len)});
				if (masked)
					repeat (4) queue_byte(8'($urandom));
				repeat (len) queue_byte(8'($urandom));
			end
		end
	endtask

	// Cycle count and run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Long receiver hold-off, counted in cycles here while the sender keeps offering
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Driver: predict on every accepted item, then offer the next pending byte or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'h00;
		end else begin
			if (s_tvalid && s_tready)
				unmask_step(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= tx_bytes.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted echo item against the oldest expectation, then stall at random
	always @(posedge clk or negedge arst_n) begin
		echo_item_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (echo_q.size() == 0) begin
					report_mismatch($sformatf("unexpected item data=%h last=%b bad=%b",
						m_tdata, m_tlast, m_tuser));
				end else begin
					want = echo_q.pop_front();
					if (m_tdata !== want.data)
						report_mismatch($sformatf("out_byte %h, want %h", m_tdata, want.data));
					if (m_tlast !== want.last)
						report_mismatch($sformatf("out_last %b, want %b", m_tlast, want.last));
					if (m_tuser !== want.bad)
						report_mismatch($sformatf("bad_length %b, want %b", m_tuser, want.bad));
				end
			end
			m_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		// Short frames hitting the corner cases: empty unmasked, empty masked with its key,
		// both extended length codes, a plain payload and a masked payload.
		logic [7:0] directed[25] = '{
			8'h00, 8'h00,
			8'hFF, 8'h80, 8'h11, 8'h22, 8'h33, 8'h44,
			8'h81, 8'h7E,
			8'h82, 8'hFF,
			8'h00, 8'h03, 8'h00, 8'hFF, 8'h5A,
			8'h81, 8'h82, 8'hA5, 8'h5A, 8'hFF, 8'h00, 8'hFF, 8'h0F
		};
		int idle_tab[4] = '{0, 61, 0, 16};
		int stall_tab[4] = '{0, 0, 61, 16};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int p = 0; p < 4; p++) begin
			send_idle_pct <= idle_tab[p];
			stall_pct <= stall_tab[p];
			if (p == 0) begin
				foreach (directed[i]) queue_byte(directed[i]);
				// Hold the output off while input keeps coming so the block backs up
				hold_req <= 1'b1;
			end
			while (queued_n < (p + 1) * PHASE_ITEMS + 25)
				queue_frame();
			while (tx_bytes.size() != 0 || s_tvalid)
				@(negedge clk);
		end

		// Drain what is still owed, then give the block a few more cycles
		while (echo_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (echo_q.size() != 0)
			report_mismatch($sformatf("%0d echo items never arrived", echo_q.size()));

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[filelist.f]
rtl/wsue_pkg.sv
rtl/wsue_front.sv
rtl/wsue_fifo.sv
rtl/wsue_back.sv
rtl/websocket_frame_unmask_echo.sv
tb/sv/tb_websocket_frame_unmask_echo.sv
